// File: design/assert_macros.svh
// Assertion macros used by blake2s_keyed_hash
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define B2S_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2s assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define B2S_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2s assertion failed");

`endif

// File: design/b2s_pkg.sv
// Constants, tables and types for the BLAKE2s keyed hash engine
`default_nettype none
package b2s_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int LAST_ROUND  = 9;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_DIGEST_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_LEN    = 3'd1;
    localparam logic [2:0] REG_KEY_0      = 3'd2;
    localparam logic [2:0] REG_KEY_1      = 3'd3;
    localparam logic [2:0] REG_KEY_2      = 3'd4;
    localparam logic [2:0] REG_KEY_3      = 3'd5;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Message word schedule, one row per round
    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

    // Control of the shared quarter-step unit
    typedef struct packed {
        logic b_step;   // 0: a/d update, 1: c/b update
        logic second;   // 0: first half of G, 1: second half
    } gstep_ctrl_t;

endpackage
`default_nettype wire

// File: design/b2s_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module b2s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/b2s_gunit.sv
// Shared G-function quarter step: one add, xor and rotate per cycle
`default_nettype none
module b2s_gunit
    import b2s_pkg::*;
(
    input  wire gstep_ctrl_t  ctrl,
    input  wire logic [31:0]  a_in,
    input  wire logic [31:0]  b_in,
    input  wire logic [31:0]  c_in,
    input  wire logic [31:0]  d_in,
    input  wire logic [31:0]  m_in,
    output logic      [31:0]  a_out,
    output logic      [31:0]  b_out,
    output logic      [31:0]  c_out,
    output logic      [31:0]  d_out
);

    logic [31:0] a_sum;
    logic [31:0] d_mix;
    logic [31:0] c_sum;
    logic [31:0] b_mix;

    // a/d half: a += b + m; d = rotr(d ^ a, 16 or 8)
    assign a_sum = a_in + b_in + m_in;
    assign d_mix = d_in ^ a_sum;
    // c/b half: c += d; b = rotr(b ^ c, 12 or 7)
    assign c_sum = c_in + d_in;
    assign b_mix = b_in ^ c_sum;

    always_comb
    begin
        a_out = a_in;
        b_out = b_in;
        c_out = c_in;
        d_out = d_in;
        if (!ctrl.b_step)
        begin
            a_out = a_sum;
            d_out = ctrl.second ? {d_mix[7:0], d_mix[31:8]} : {d_mix[15:0], d_mix[31:16]};
        end
        else
        begin
            c_out = c_sum;
            b_out = ctrl.second ? {b_mix[6:0], b_mix[31:7]} : {b_mix[11:0], b_mix[31:12]};
        end
    end

endmodule
`default_nettype wire

// File: design/blake2s_keyed_hash.sv
// BLAKE2s keyed hash engine: byte buffer, shared G unit and sequencer
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start, busy          | action, data_word, byte_count
//  config    | cfg_write            | cfg_index, cfg_data
//  result    | done (per word)      | digest_word, word_index, valid_bytes,
//            |                      | last_word
//
// A transaction is taken when start is high and busy low. Absorb stores the
// bytes one at a time and then returns to idle; a byte that lands on a full
// buffer first waits for a compression. Opening a keyed message first loads
// the zero-padded key block. Each compression is 10 rounds of 8 G functions,
// each stepped through the one quarter-step unit and the message RAM port.
// Finalize is a compression followed by one digest word a cycle.
// Reset is asynchronous; the receiver cannot stall results.
`default_nettype none
`include "assert_macros.svh"
module blake2s_keyed_hash
    import b2s_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output logic             done,
    output logic      [31:0] digest_word,
    output logic      [2:0]  word_index,
    output logic      [2:0]  valid_bytes,
    output logic             last_word
);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_BYTE, S_CINIT, S_ROUND, S_CDONE, S_EMIT
    } state_t;

    state_t      state_reg;
    logic        open_reg;
    logic [6:0]  fill_reg;
    logic [5:0]  dlen_reg;
    logic [5:0]  klen_reg;
    logic [63:0] key_reg [4];
    logic        action_reg;
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  bidx_reg;
    logic        final_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [16];
    logic [63:0] t_reg;
    logic [31:0] stage_reg;
    logic [3:0]  kw_reg;
    logic [3:0]  round_reg;
    logic [2:0]  g_reg;
    logic [2:0]  ph_reg;
    logic [3:0]  ridx_reg;
    logic [2:0]  oi_reg;
    logic [5:0]  odl_reg;
    logic        done_reg;
    logic [31:0] dword_reg;
    logic [2:0]  widx_reg;
    logic [2:0]  vb_reg;
    logic        last_reg;

    logic [5:0]  eff_dl;
    logic [5:0]  eff_kl;
    logic [31:0] param_word;
    logic [31:0] key_word;
    logic [7:0]  byte_cur;
    logic [63:0] t_sum;
    logic [31:0] m_word;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic        ram_re;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;
    gstep_ctrl_t g_ctrl;
    logic [31:0] ga, gb, gc, gd;
    logic [31:0] v_g [16];
    logic [31:0] v_rot [16];
    logic [1:0]  row_sh [4];
    logic [5:0]  emit_left;
    logic [2:0]  emit_vb;
    logic [31:0] emit_word;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign digest_word = dword_reg;
    assign word_index  = widx_reg;
    assign valid_bytes = vb_reg;
    assign last_word   = last_reg;

    // Clamped lengths and parameter block word
    assign eff_dl = (dlen_reg == 6'd0) ? 6'd1 : ((dlen_reg > 6'd32) ? 6'd32 : dlen_reg);
    assign eff_kl = (klen_reg > 6'd32) ? 6'd32 : klen_reg;
    assign param_word = {8'h01, 8'h01, 2'b00, eff_kl, 2'b00, eff_dl};

    // Key word for the load sweep, bytes beyond the key length zeroed
    always_comb
    begin
        key_word = key_reg[kw_reg[2:1]][{kw_reg[0], 5'b00000} +: 32];
        for (int b = 0; b < 4; b++)
        begin
            if (kw_reg[3] || ({kw_reg[2:0], 2'b00} + 6'(b)) >= eff_kl)
            begin
                key_word[8*b +: 8] = 8'h00;
            end
        end
    end

    assign byte_cur = data_reg[{bidx_reg[1:0], 3'b000} +: 8];
    assign t_sum    = t_reg + 64'(final_reg ? fill_reg : 7'(BLOCK_BYTES));

    // Message word: RAM, partial word in staging, or zero padding
    always_comb
    begin
        if ({1'b0, ridx_reg} < fill_reg[6:2])
        begin
            m_word = ram_rdata;
        end
        else if ({1'b0, ridx_reg} == fill_reg[6:2] && fill_reg[1:0] != 2'b00)
        begin
            m_word = stage_reg;
        end
        else
        begin
            m_word = 32'h0;
        end
    end

    // Block buffer port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[5:2];
        ram_wdata = {byte_cur, stage_reg[23:0]};
        ram_re    = 1'b0;
        ram_raddr = SIGMA[round_reg][{g_reg[1:0], g_reg[2], 1'b0} ^ {g_reg[1:0], g_reg[2], 1'b0}
                    ^ {g_reg, 1'b0}];
        unique case (state_reg)
            S_KEY:
            begin
                ram_we    = 1'b1;
                ram_waddr = kw_reg;
                ram_wdata = key_word;
            end
            S_BYTE:
            begin
                ram_we = (bidx_reg != cnt_reg) && (fill_reg != 7'(BLOCK_BYTES))
                         && (fill_reg[1:0] == 2'b11);
            end
            S_ROUND:
            begin
                ram_re = (ph_reg == 3'd0) || (ph_reg == 3'd1);
                if (ph_reg == 3'd1)
                begin
                    ram_raddr = SIGMA[round_reg][{g_reg, 1'b1}];
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    b2s_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Quarter step on the column held at row position zero
    assign g_ctrl.b_step = (ph_reg == 3'd2) || (ph_reg == 3'd4);
    assign g_ctrl.second = (ph_reg == 3'd3) || (ph_reg == 3'd4);

    b2s_gunit u_g (
        .ctrl  (g_ctrl),
        .a_in  (v_reg[0]),
        .b_in  (v_reg[4]),
        .c_in  (v_reg[8]),
        .d_in  (v_reg[12]),
        .m_in  (m_word),
        .a_out (ga),
        .b_out (gb),
        .c_out (gc),
        .d_out (gd)
    );

    // Row rotation after each G; skews rows for the diagonal pass and back
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            row_sh[r] = 2'd1;
        end
        if (g_reg == 3'd3)
        begin
            row_sh[1] = 2'd2;
            row_sh[2] = 2'd3;
            row_sh[3] = 2'd0;
        end
        else if (g_reg == 3'd7)
        begin
            row_sh[1] = 2'd0;
            row_sh[2] = 2'd3;
            row_sh[3] = 2'd2;
        end
        for (int i = 0; i < 16; i++)
        begin
            v_g[i] = v_reg[i];
        end
        v_g[0]  = ga;
        v_g[4]  = gb;
        v_g[8]  = gc;
        v_g[12] = gd;
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v_rot[4*r + k] = v_g[{2'(r), 2'(k) + row_sh[r]}];
            end
        end
    end

    // Digest word shaping
    assign emit_left = odl_reg - {1'b0, oi_reg, 2'b00};
    assign emit_vb   = (emit_left > 6'd4) ? 3'd4 : emit_left[2:0];
    always_comb
    begin
        emit_word = h_reg[oi_reg];
        for (int b = 0; b < 4; b++)
        begin
            if (3'(b) >= emit_vb)
            begin
                emit_word[8*b +: 8] = 8'h00;
            end
        end
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            open_reg   <= 1'b0;
            fill_reg   <= '0;
            dlen_reg   <= 6'd32;
            klen_reg   <= 6'd0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            action_reg <= 1'b0;
            data_reg   <= '0;
            cnt_reg    <= '0;
            bidx_reg   <= '0;
            final_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= '0;
            end
            t_reg      <= '0;
            stage_reg  <= '0;
            kw_reg     <= '0;
            round_reg  <= '0;
            g_reg      <= '0;
            ph_reg     <= '0;
            ridx_reg   <= '0;
            oi_reg     <= '0;
            odl_reg    <= '0;
            done_reg   <= 1'b0;
            dword_reg  <= '0;
            widx_reg   <= '0;
            vb_reg     <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes; unknown indexes are dropped
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DIGEST_LEN: dlen_reg   <= cfg_data[5:0];
                    REG_KEY_LEN:    klen_reg   <= cfg_data[5:0];
                    REG_KEY_0:      key_reg[0] <= cfg_data;
                    REG_KEY_1:      key_reg[1] <= cfg_data;
                    REG_KEY_2:      key_reg[2] <= cfg_data;
                    REG_KEY_3:      key_reg[3] <= cfg_data;
                    default:        dlen_reg   <= dlen_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg <= action;
                        data_reg   <= data_word;
                        cnt_reg    <= (byte_count > 3'd4) ? 3'd4 : byte_count;
                        bidx_reg   <= '0;
                        final_reg  <= action;
                        if (!open_reg)
                        begin
                            // New message: chain from IV and parameter word
                            h_reg[0] <= IV[0] ^ param_word;
                            for (int i = 1; i < 8; i++)
                            begin
                                h_reg[i] <= IV[i];
                            end
                            t_reg    <= '0;
                            fill_reg <= '0;
                            open_reg <= 1'b1;
                            kw_reg   <= '0;
                        end
                        if (!open_reg && eff_kl != 6'd0)
                        begin
                            state_reg <= S_KEY;
                        end
                        else
                        begin
                            state_reg <= action ? S_CINIT : S_BYTE;
                        end
                    end
                end

                S_KEY:
                begin
                    kw_reg <= kw_reg + 4'd1;
                    if (kw_reg == 4'd15)
                    begin
                        fill_reg  <= 7'(BLOCK_BYTES);
                        state_reg <= action_reg ? S_CINIT : S_BYTE;
                    end
                end

                S_BYTE:
                begin
                    if (bidx_reg == cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (fill_reg == 7'(BLOCK_BYTES))
                    begin
                        final_reg <= 1'b0;
                        state_reg <= S_CINIT;
                    end
                    else
                    begin
                        if (fill_reg[1:0] == 2'b00)
                        begin
                            stage_reg <= {24'h0, byte_cur};
                        end
                        else
                        begin
                            stage_reg[{fill_reg[1:0], 3'b000} +: 8] <= byte_cur;
                        end
                        fill_reg <= fill_reg + 7'd1;
                        bidx_reg <= bidx_reg + 3'd1;
                    end
                end

                S_CINIT:
                begin
                    t_reg <= t_sum;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i]     <= h_reg[i];
                        v_reg[i + 8] <= IV[i];
                    end
                    v_reg[12] <= IV[4] ^ t_sum[31:0];
                    v_reg[13] <= IV[5] ^ t_sum[63:32];
                    v_reg[14] <= final_reg ? ~IV[6] : IV[6];
                    round_reg <= '0;
                    g_reg     <= '0;
                    ph_reg    <= '0;
                    state_reg <= S_ROUND;
                end

                S_ROUND:
                begin
                    if (ph_reg == 3'd0 || ph_reg == 3'd1)
                    begin
                        ridx_reg <= ram_raddr;
                    end
                    if (ph_reg == 3'd4)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            v_reg[i] <= v_rot[i];
                        end
                        ph_reg <= 3'd0;
                        g_reg  <= g_reg + 3'd1;
                        if (g_reg == 3'd7)
                        begin
                            round_reg <= round_reg + 4'd1;
                            if (round_reg == 4'(LAST_ROUND))
                            begin
                                state_reg <= S_CDONE;
                            end
                        end
                    end
                    else
                    begin
                        if (ph_reg != 3'd0)
                        begin
                            v_reg[0]  <= ga;
                            v_reg[4]  <= gb;
                            v_reg[8]  <= gc;
                            v_reg[12] <= gd;
                        end
                        ph_reg <= ph_reg + 3'd1;
                    end
                end

                S_CDONE:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                    end
                    fill_reg <= '0;
                    if (final_reg)
                    begin
                        open_reg  <= 1'b0;
                        oi_reg    <= '0;
                        odl_reg   <= eff_dl;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_BYTE;
                    end
                end

                S_EMIT:
                begin
                    done_reg  <= 1'b1;
                    dword_reg <= emit_word;
                    widx_reg  <= oi_reg;
                    vb_reg    <= emit_vb;
                    last_reg  <= (emit_left <= 6'd4);
                    oi_reg    <= oi_reg + 3'd1;
                    if (emit_left <= 6'd4)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A result only follows a cycle of digest output
    `B2S_ASSERT_IMP(a_done_from_emit, done, $past(state_reg == S_EMIT))
    // The final word of a digest closes the burst
    `B2S_ASSERT_NXT(a_last_ends, done && last_word, !done)
    // A burst opens at word zero
    `B2S_ASSERT_IMP(a_first_index, done && !$past(done), word_index == 3'd0)
    // The buffer never holds more than one block
    `B2S_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= 7'(BLOCK_BYTES))

endmodule
`default_nettype wire
